// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

// File: hdl/eti_pkg.sv
// ----------------------------------------------------------------------------
// Eased tween interpolator package
// Types and fixed constants shared by the tween datapath and sequencer.
// ----------------------------------------------------------------------------
package eti_pkg;

  localparam int DUR_W     = 26;   // duration in ms times 1000 stays below 2**26
  localparam int T_W       = 16;   // Q0.16 progress
  localparam int MUL_B_W   = 20;   // largest easing operand is 262144 - 2t
  localparam int MS_TO_US  = 1000;
  localparam int DIV_STEPS = 16;

  typedef enum logic [1:0] {
    REG_FROM_VAL    = 2'd0,
    REG_TO_VAL      = 2'd1,
    REG_SPAN_MS     = 2'd2,
    REG_EASING_MODE = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    EASE_LIN    = 2'd0,
    EASE_IN     = 2'd1,
    EASE_QOUT   = 2'd2,
    EASE_QINOUT = 2'd3
  } easing_e;

  typedef enum logic {
    ACT_START  = 1'b0,
    ACT_UPDATE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    MUL_DUR  = 2'd0,
    MUL_EASE = 2'd1,
    MUL_LERP = 2'd2
  } mul_op_e;

  typedef struct packed {
    logic    en;
    mul_op_e op;
    easing_e mode;
  } arith_ctrl_t;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_DUR  = 9'b000000010,
    ST_CMP  = 9'b000000100,
    ST_DIV  = 9'b000001000,
    ST_EASE = 9'b000010000,
    ST_ESEL = 9'b000100000,
    ST_LERP = 9'b001000000,
    ST_FIN  = 9'b010000000,
    ST_OUT  = 9'b100000000
  } state_e;

endpackage

// File: hdl/eased_tween_interpolator.sv
// ----------------------------------------------------------------------------
// Eased tween interpolator
// Time-driven tween between two signed fixed-point values with quadratic
// easing, computed by a small sequencer around one multiplier and one
// subtractor.
// ----------------------------------------------------------------------------
// A start item (tuser = 0) latches now_us as the begin time, returns the
// start register and arms the tween. An update item (tuser = 1) measures the
// wrapping elapsed time; at or past the duration register times 1000 us it
// returns the end register with done_res set, otherwise it returns the eased
// intermediate value with still_running set. Updates while idle or done
// return the held value. Counted from the accepting cycle through the cycle
// at whose end the result register loads, a start item or an update while
// idle or done passes the accept and output steps; an update that reaches
// the end also passes the duration scale and the compare; an update that
// yields an intermediate value passes the duration scale, the compare, the
// 16-step restoring divide that forms the Q0.16 progress on the shared
// subtractor, the easing square, the easing select, the interpolation
// product and the final add, with three passes through the multiplier.
// The input is ready again in the next cycle, so a new item is taken only
// after the last one's result has loaded. The input is not ready while
// an item is in work; a finished result waits in the output register, and
// the next item may be taken meanwhile; its own result then holds in the
// last step until the waiting one is taken.
// Configuration writes take effect at the next update.
// ----------------------------------------------------------------------------
module eased_tween_interpolator
  import eti_pkg::*;
#(
  parameter int VALUE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [((VALUE_BITS > 16) ? VALUE_BITS : 16)-1:0] cfg_data_i,
  // input items
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [31:0]            s_axis_tdata,   // [31:0] now_us
  input  logic                   s_axis_tuser,   // [0] action
  // result items
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata, // [VALUE_BITS-1:0] value
  output logic [1:0]             m_axis_tuser    // [0] still_running, [1] done_res
);

  localparam int OUT_DW = ((VALUE_BITS + 7) / 8) * 8;
  localparam int MA_W   = (VALUE_BITS + 1 > 17) ? VALUE_BITS + 1 : 17;
  localparam int P_W    = MA_W + MUL_B_W;
  localparam int CNT_W  = $clog2(DIV_STEPS);

  // Configuration registers.
  logic signed [VALUE_BITS-1:0] start_q, end_q;
  logic [15:0]                  duration_q;
  easing_e                      mode_q;

  // Tween state.
  logic [31:0]                  begin_q;
  logic                         running_q;
  logic                         finished_q;
  logic signed [VALUE_BITS-1:0] held_q;

  // Work registers.
  state_e                       state_q, state_d;
  logic [31:0]                  elapsed_q;
  logic [DUR_W-1:0]             rem_q;
  logic [T_W-1:0]               t_q;
  logic [T_W-1:0]               e_q;
  logic [CNT_W-1:0]             cnt_q;
  logic                         live_q;

  // Output register.
  logic                         m_valid_q;
  logic [VALUE_BITS-1:0]        out_value_q;
  logic                         out_run_q, out_done_q;

  logic                         in_acc;
  logic                         out_free;
  arith_ctrl_t                  mul_ctrl;
  logic signed [P_W-1:0]        prod;
  logic [DUR_W-1:0]             dur;
  logic signed [VALUE_BITS:0]   diff;
  logic [32:0]                  sub_a, sub_b;
  logic [33:0]                  sub_r;
  logic                         sub_ge;
  logic [DUR_W:0]               rem_dbl;
  logic [T_W-1:0]               e_sel;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // Scaled duration sits in the product register from ST_CMP through ST_DIV.
  assign dur  = prod[DUR_W-1:0];
  assign diff = (VALUE_BITS + 1)'(end_q) - (VALUE_BITS + 1)'(start_q);

  // Shared subtractor: end-of-tween compare, then one divide step a cycle.
  assign rem_dbl = {rem_q, 1'b0};
  always_comb begin
    if (state_q == ST_DIV) begin
      sub_a = 33'(rem_dbl);
    end else begin
      sub_a = {1'b0, elapsed_q};
    end
    sub_b  = 33'(dur);
    sub_r  = {1'b0, sub_a} - {1'b0, sub_b};
    sub_ge = !sub_r[33];
  end

  // Multiplier control.
  always_comb begin
    mul_ctrl.en   = 1'b0;
    mul_ctrl.op   = MUL_DUR;
    mul_ctrl.mode = mode_q;
    case (state_q)
      ST_DUR: begin
        mul_ctrl.en = 1'b1;
        mul_ctrl.op = MUL_DUR;
      end
      ST_EASE: begin
        mul_ctrl.en = 1'b1;
        mul_ctrl.op = MUL_EASE;
      end
      ST_LERP: begin
        mul_ctrl.en = 1'b1;
        mul_ctrl.op = MUL_LERP;
      end
      default: mul_ctrl.en = 1'b0;
    endcase
  end

  eti_mul_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mul_ctrl),
    .span_ms_i(duration_q),
    .t_i      (t_q),
    .diff_i   (diff),
    .ease_i   (e_q),
    .prod_o   (prod)
  );

  // Reduce the easing product to Q0.16.
  always_comb begin
    case (mode_q)
      EASE_IN, EASE_QOUT: e_sel = prod[31:16];
      EASE_QINOUT: begin
        if (t_q[T_W-1]) begin
          e_sel = T_W'(prod[32:16] - 17'h10000);
        end else begin
          e_sel = prod[30:15];
        end
      end
      default: e_sel = t_q;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == ACT_UPDATE && running_q && !finished_q) begin
            state_d = ST_DUR;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_DUR:  state_d = ST_CMP;
      ST_CMP:  state_d = sub_ge ? ST_OUT : ST_DIV;
      ST_DIV:  state_d = (cnt_q == CNT_W'(DIV_STEPS - 1)) ? ST_EASE : ST_DIV;
      ST_EASE: state_d = ST_ESEL;
      ST_ESEL: state_d = ST_LERP;
      ST_LERP: state_d = ST_FIN;
      ST_FIN:  state_d = ST_OUT;
      ST_OUT:  state_d = out_free ? ST_IDLE : ST_OUT;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      begin_q    <= '0;
      running_q  <= 1'b0;
      finished_q <= 1'b0;
      held_q     <= '0;
      live_q     <= 1'b0;
      cnt_q      <= '0;
      start_q    <= '0;
      end_q      <= '0;
      duration_q <= '0;
      mode_q     <= EASE_LIN;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FROM_VAL:    start_q    <= cfg_data_i[VALUE_BITS-1:0];
          REG_TO_VAL:      end_q      <= cfg_data_i[VALUE_BITS-1:0];
          REG_SPAN_MS:     duration_q <= cfg_data_i[15:0];
          REG_EASING_MODE: mode_q     <= easing_e'(cfg_data_i[1:0]);
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            live_q <= 1'b0;
            if (s_axis_tuser == ACT_START) begin
              begin_q    <= s_axis_tdata;
              held_q     <= start_q;
              running_q  <= 1'b1;
              finished_q <= 1'b0;
            end
          end
        end
        ST_CMP: begin
          cnt_q <= '0;
          if (sub_ge) begin
            held_q     <= end_q;
            finished_q <= 1'b1;
            running_q  <= 1'b0;
          end
        end
        ST_DIV:  cnt_q <= cnt_q + 1'b1;
        ST_FIN: begin
          held_q <= start_q + VALUE_BITS'(prod >>> 16);
          live_q <= 1'b1;
        end
        default: ;
      endcase

      // Hold the result until taken, reload when a new one is ready.
      if (state_q == ST_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      elapsed_q <= s_axis_tdata - begin_q;
    end
    case (state_q)
      ST_CMP: begin
        rem_q <= elapsed_q[DUR_W-1:0];
        t_q   <= '0;
      end
      ST_DIV: begin
        if (sub_ge) begin
          rem_q <= sub_r[DUR_W-1:0];
        end else begin
          rem_q <= rem_dbl[DUR_W-1:0];
        end
        t_q <= {t_q[T_W-2:0], sub_ge};
      end
      ST_ESEL: e_q <= e_sel;
      default: ;
    endcase
    if (state_q == ST_OUT && out_free) begin
      out_value_q <= held_q;
      out_run_q   <= live_q;
      out_done_q  <= finished_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_DW'(out_value_q);
  assign m_axis_tuser  = {out_done_q, out_run_q};

endmodule

// File: hdl/eti_mul_unit.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// One signed multiplier with registered product, reused for the duration
// scale, the easing square and the final interpolation.
// ----------------------------------------------------------------------------
module eti_mul_unit
  import eti_pkg::*;
#(
  parameter int VALUE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  arith_ctrl_t                           ctrl_i,
  input  logic [15:0]                           span_ms_i,
  input  logic [T_W-1:0]                        t_i,
  input  logic signed [VALUE_BITS:0]            diff_i,
  input  logic [T_W-1:0]                        ease_i,
  output logic signed [((VALUE_BITS + 1 > 17) ? VALUE_BITS + 1 : 17) + MUL_B_W - 1:0] prod_o
);

  localparam int MA_W = (VALUE_BITS + 1 > 17) ? VALUE_BITS + 1 : 17;
  localparam int P_W  = MA_W + MUL_B_W;

  logic signed [MA_W-1:0]    op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [P_W-1:0]     prod_d, prod_q;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (ctrl_i.op)
      MUL_DUR: begin
        op_a = MA_W'(span_ms_i);
        op_b = MUL_B_W'(MS_TO_US);
      end
      MUL_EASE: begin
        op_a = MA_W'(t_i);
        case (ctrl_i.mode)
          EASE_QOUT:   op_b = MUL_B_W'(20'd131072 - MUL_B_W'(t_i));
          EASE_QINOUT: begin
            if (t_i[T_W-1]) begin
              op_b = MUL_B_W'(20'd262144 - MUL_B_W'({t_i, 1'b0}));
            end else begin
              op_b = MUL_B_W'(t_i);
            end
          end
          default:     op_b = MUL_B_W'(t_i);
        endcase
      end
      MUL_LERP: begin
        op_a = MA_W'(diff_i);
        op_b = MUL_B_W'(ease_i);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    prod_d = P_W'(op_a) * P_W'(op_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
    end else if (ctrl_i.en) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// File: hdl/eti_checker.sv
// ----------------------------------------------------------------------------
// Eased tween interpolator checker
// Port-level assertions on the handshakes and result flags, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eti_checker #(
  parameter int VALUE_BITS = 16
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  input logic [1:0]             m_axis_tuser
);

  logic in_acc;
  logic out_stall;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // One item in work at a time: input closes right after an acceptance.
  `ASSERT_NEXT(a_busy_after_accept, in_acc, !s_axis_tready)
  // An intermediate value is never also the final one.
  `ASSERT_SAME(a_flags_exclusive, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]))
  // Stalled result stays offered.
  `ASSERT_NEXT(a_out_valid_holds, out_stall, m_axis_tvalid)
  // Stalled result holds its payload.
  `ASSERT_NEXT(a_out_data_holds, out_stall, $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind eased_tween_interpolator eti_checker #(.VALUE_BITS(VALUE_BITS)) u_eti_checker (.*);

// File: tb/tb_eased_tween_interpolator.sv
// ----------------------------------------------------------------------------
// Eased tween interpolator testbench
// Drives start and update items into the tween block, predicts every result
// from its own model of the tween state, and compares the value and flag
// fields of each result item in order. A short directed table comes first,
// then random register settings with mostly well-formed tween sequences.
// ----------------------------------------------------------------------------
module tb_eased_tween_interpolator
  import eti_pkg::*;
();

  localparam int VALUE_W      = 16;
  localparam int SETTLE       = 30;      // outlasts a running update
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 24;
  localparam int PHASE_ITEMS  = 35;
  localparam int PRINT_CAP    = 40;

  // One result item: value in tdata, flags in tuser.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               live;
    logic               done;
  } tween_out_t;

  typedef enum logic {
    ROW_WRITE,
    ROW_ITEM
  } row_kind_e;

  // One row of the directed table; data is now_us for items and the
  // register value for writes.
  typedef struct packed {
    row_kind_e  kind;
    cfg_reg_e   reg_idx;
    logic [31:0] data;
    action_e    act;
    logic       has_want;
    tween_out_t want;
  } stim_row_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [1:0]           cfg_idx_i     = '0;
  logic [VALUE_W-1:0]   cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata  = '0;   // [31:0] now_us
  logic                 s_axis_tuser  = 1'b0; // [0] action
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [VALUE_W-1:0]   m_axis_tdata;         // [15:0] value
  logic [1:0]           m_axis_tuser;         // [0] still_running, [1] done_res

  // Register copies and tween state of the predictor.
  logic signed [VALUE_W-1:0] cfg_start  = '0;
  logic signed [VALUE_W-1:0] cfg_end    = '0;
  logic [15:0]               cfg_dur_ms = '0;
  easing_e                   cfg_mode   = EASE_LIN;
  logic [31:0]               tween_begin_us = '0;
  logic                      tween_running  = 1'b0;
  logic                      tween_finished = 1'b0;
  logic [VALUE_W-1:0]        tween_value    = '0;

  tween_out_t pending_results [$];
  stim_row_t  directed_rows [$];
  int         mismatch_count = 0;
  int         items_sent     = 0;
  int         cycle_count    = 0;
  bit         calm           = 1'b0;  // set: neither side idles

  eased_tween_interpolator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Eased progress in Q0.16; the result may reach 65536 only in theory.
  function automatic logic [16:0] ease_progress(logic [15:0] t, easing_e mode);
    longint unsigned tl;
    tl = 64'(t);
    case (mode)
      EASE_IN:   return 17'((tl * tl) >> 16);
      EASE_QOUT: return 17'((tl * (131072 - tl)) >> 16);
      EASE_QINOUT: begin
        // first half 2t^2, second half -1 + (4 - 2t)t
        if (tl < 32768) return 17'((tl * tl) >> 15);
        return 17'(((tl * (262144 - 2 * tl)) >> 16) - 65536);
      end
      default:   return 17'(tl);
    endcase
  endfunction

  // Advance the tween state by one item and return the result it causes.
  function automatic tween_out_t predict_tween(action_e act, logic [31:0] now);
    tween_out_t      res;
    logic [31:0]     elapsed32;
    longint unsigned elapsed;
    longint unsigned dur_us;
    longint unsigned t;
    longint          s;
    longint          d;
    longint          e;
    logic            live;
    live = 1'b0;
    if (act == ACT_START) begin
      tween_begin_us = now;
      tween_value    = cfg_start;
      tween_running  = 1'b1;
      tween_finished = 1'b0;
    end else if (tween_running && !tween_finished) begin
      elapsed32 = now - tween_begin_us;   // wraps in 32 bits
      elapsed   = 64'(elapsed32);
      dur_us    = 64'(cfg_dur_ms) * 64'd1000;
      if (elapsed >= dur_us) begin
        // also covers zero duration, where no divide happens
        tween_value    = cfg_end;
        tween_finished = 1'b1;
        tween_running  = 1'b0;
      end else begin
        t = (elapsed << 16) / dur_us;
        e = longint'(ease_progress(16'(t), cfg_mode));
        s = longint'(cfg_start);
        d = longint'(cfg_end) - s;
        tween_value = VALUE_W'(s + ((d * e) >>> 16));  // floor toward minus
        live = 1'b1;
      end
    end
    res.value = tween_value;
    res.live  = live;
    res.done  = tween_finished;
    return res;
  endfunction

  function automatic stim_row_t cfg_row(cfg_reg_e idx, logic [15:0] v);
    stim_row_t r;
    r = '0;
    r.kind    = ROW_WRITE;
    r.reg_idx = idx;
    r.data    = {16'h0, v};
    r.act     = ACT_START;
    return r;
  endfunction

  function automatic stim_row_t item_row(action_e a, logic [31:0] now);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.data = now;
    r.act  = a;
    return r;
  endfunction

  function automatic stim_row_t known_row(action_e a, logic [31:0] now,
                                          logic [15:0] v, logic live, logic done);
    stim_row_t r;
    r = item_row(a, now);
    r.has_want   = 1'b1;
    r.want.value = v;
    r.want.live  = live;
    r.want.done  = done;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned want,
                                 longint unsigned got);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("mismatch at cycle %0d: %s expected %0h got %0h",
               cycle_count, what, want, got);
  endtask

  // Hand one item to the block; record its expected result on acceptance.
  task automatic send_item(action_e act, logic [31:0] now, logic has_want,
                           tween_out_t want);
    tween_out_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= now;
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = predict_tween(act, now);
    // a typed row overrides the prediction, the state still advances
    pending_results.push_back(has_want ? want : predicted);
    items_sent++;
    // idle the input side at random
    while (!calm && $urandom_range(99) < 34) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Drain the block, let it settle, then write one register.
  task automatic write_cfg(cfg_reg_e idx, logic [15:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_FROM_VAL: cfg_start  = v;
      REG_TO_VAL:   cfg_end    = v;
      REG_SPAN_MS:  cfg_dur_ms = v;
      default:      cfg_mode   = easing_e'(v[1:0]);
    endcase
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_duration();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h0001;
      3:       return 16'($urandom_range(20, 1));
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly a start, a few updates inside the duration and one at or past
  // the end; the rest is single items with random content.
  task automatic run_tween_sequence();
    logic [31:0] base;
    logic [31:0] dur_us;
    int          n;
    dur_us = cfg_dur_ms * 1000;
    if ($urandom_range(99) < 75) begin
      base = $urandom;
      send_item(ACT_START, base, 1'b0, '0);
      n = $urandom_range(6, 1);
      if (dur_us != 0) begin
        repeat (n) send_item(ACT_UPDATE, base + $urandom_range(dur_us - 1, 0),
                             1'b0, '0);
      end
      if ($urandom_range(99) < 80)
        send_item(ACT_UPDATE,
                  base + dur_us + ($urandom_range(1) ? 0 : $urandom_range(1000, 1)),
                  1'b0, '0);
      if ($urandom_range(3) == 0)
        send_item(ACT_UPDATE, $urandom, 1'b0, '0);
    end else begin
      send_item(action_e'($urandom_range(1)), $urandom, 1'b0, '0);
    end
  endtask

  // Output side: stall at random, except in the calm stretch.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 34);
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    tween_out_t got;
    tween_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.value = m_axis_tdata;
      got.live  = m_axis_tuser[0];
      got.done  = m_axis_tuser[1];
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item pending", 64'd0, 64'(got));
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value)
          report_mismatch("value", 64'(want.value), 64'(got.value));
        if (got.live !== want.live)
          report_mismatch("still_running", 64'(want.live), 64'(got.live));
        if (got.done !== want.done)
          report_mismatch("done_res", 64'(want.done), 64'(got.done));
      end
    end
  end

  initial begin
    // Directed table. Rows with a typed result are read straight off the
    // rules: idle after reset, start value, end value, zero duration.
    directed_rows = '{
      known_row(ACT_UPDATE, 32'h0, 16'h0000, 1'b0, 1'b0),   // idle after reset
      cfg_row(REG_FROM_VAL,    16'h8000),
      cfg_row(REG_TO_VAL,      16'h7FFF),
      cfg_row(REG_SPAN_MS,     16'd1),
      cfg_row(REG_EASING_MODE, 16'(EASE_LIN)),
      known_row(ACT_START,  32'hFFFF_FF00, 16'h8000, 1'b0, 1'b0),
      item_row(ACT_UPDATE,  32'h0000_00F4),                 // elapsed wraps to 500
      item_row(ACT_UPDATE,  32'h0000_02E7),                 // one short of the end
      known_row(ACT_UPDATE, 32'h0000_02E8, 16'h7FFF, 1'b0, 1'b1),
      known_row(ACT_UPDATE, 32'h1234_5678, 16'h7FFF, 1'b0, 1'b1), // after done
      cfg_row(REG_EASING_MODE, 16'(EASE_IN)),
      known_row(ACT_START,  32'd0, 16'h8000, 1'b0, 1'b0),
      item_row(ACT_UPDATE,  32'd250),
      item_row(ACT_UPDATE,  32'd500),
      cfg_row(REG_EASING_MODE, 16'(EASE_QOUT)),
      known_row(ACT_START,  32'd100, 16'h8000, 1'b0, 1'b0),
      item_row(ACT_UPDATE,  32'd350),
      item_row(ACT_UPDATE,  32'd1099),
      cfg_row(REG_EASING_MODE, 16'(EASE_QINOUT)),
      known_row(ACT_START,  32'd0, 16'h8000, 1'b0, 1'b0),
      item_row(ACT_UPDATE,  32'd499),
      item_row(ACT_UPDATE,  32'd500),                       // half way point
      item_row(ACT_UPDATE,  32'd501),
      item_row(ACT_UPDATE,  32'd999),
      cfg_row(REG_SPAN_MS,     16'd0),
      known_row(ACT_START,  32'd5, 16'h8000, 1'b0, 1'b0),
      known_row(ACT_UPDATE, 32'd5, 16'h7FFF, 1'b0, 1'b1),   // zero duration
      cfg_row(REG_FROM_VAL,    16'h7FFF),
      cfg_row(REG_TO_VAL,      16'h8000),
      cfg_row(REG_SPAN_MS,     16'hFFFF),
      cfg_row(REG_EASING_MODE, 16'(EASE_LIN)),
      known_row(ACT_START,  32'd0, 16'h7FFF, 1'b0, 1'b0),
      item_row(ACT_UPDATE,  32'd0),                         // zero progress
      known_row(ACT_UPDATE, 32'hFFFF_FFFF, 16'h8000, 1'b0, 1'b1),
      known_row(ACT_START,  32'd1000, 16'h7FFF, 1'b0, 1'b0),
      cfg_row(REG_EASING_MODE, 16'(EASE_IN)),               // change mid-tween
      item_row(ACT_UPDATE,  32'd32768500)
    };

    // Hold reset, then release it on a clock edge.
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        write_cfg(directed_rows[i].reg_idx, directed_rows[i].data[15:0]);
      end else begin
        send_item(directed_rows[i].act, directed_rows[i].data,
                  directed_rows[i].has_want, directed_rows[i].want);
      end
    end

    // Random phases: fresh registers each phase, tween state carried over,
    // so some register changes land in the middle of a running tween.
    for (int phase = 0; phase < PHASES; phase++) begin
      int target;
      calm = (phase >= 9 && phase < 12);
      write_cfg(REG_FROM_VAL,    pick_value());
      write_cfg(REG_TO_VAL,      pick_value());
      write_cfg(REG_SPAN_MS,     pick_duration());
      write_cfg(REG_EASING_MODE, 16'($urandom_range(3)));
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) run_tween_sequence();
    end
    calm = 1'b0;

    // Drop valid, drain the results, then give stray results time to show.
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/eti_pkg.sv
hdl/eti_mul_unit.sv
hdl/eased_tween_interpolator.sv
hdl/eti_checker.sv
tb/tb_eased_tween_interpolator.sv
